[rtl/ecpp_pkg.sv]
// ----------------------------------------------------------------------------
// ecpp_pkg
// Shared types and constants for the event candidate unpack and pair pack unit.
// ----------------------------------------------------------------------------
package ecpp_pkg;

  localparam int MAX_CANDIDATES = 64;
  localparam int CNT_W          = $clog2(MAX_CANDIDATES + 1);
  localparam int BANK_DEPTH     = (MAX_CANDIDATES + 1) / 2;
  localparam int BANK_AW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);

  localparam logic       OP_HEADER = 1'b0;
  localparam logic       OP_CAND   = 1'b1;
  localparam logic [3:0] KEEP_FULL = 4'hF;
  localparam logic [3:0] KEEP_HALF = 4'h3;
  localparam logic [1:0] PORT_LAST = 2'd2;

  typedef struct packed {
    logic        op;
    logic [63:0] word;
  } req_t;

  typedef struct packed {
    logic [1:0]  port;
    logic [31:0] first_word;
    logic [31:0] second_word;
    logic [3:0]  byte_keep;
    logic        stream_last;
    logic        run_end;
  } res_t;

  // One command from the front to the back: an optional result, an optional
  // eta/phi store write and an optional eta/phi drain.
  typedef struct packed {
    res_t             res;
    logic             has_out;
    logic             wr_en;
    logic [CNT_W-1:0] wr_idx;
    logic [15:0]      eta;
    logic [15:0]      phi;
    logic             drain;
    logic [CNT_W-1:0] total;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_CMD,
    ST_READ,
    ST_EMIT
  } back_state_t;

endpackage

[rtl/ecpp_front.sv]
// ----------------------------------------------------------------------------
// ecpp_front
// Accepts header and candidate words, tracks the open event and turns each
// header and each candidate of the open event into a back end command.
// ----------------------------------------------------------------------------
module ecpp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  ecpp_pkg::req_t      req,
  input  logic                q_full,
  output logic                push,
  output ecpp_pkg::cmd_t      cmd
);

  logic [1:0]                 port, port_next;
  logic [ecpp_pkg::CNT_W-1:0] expected, expected_next;
  logic [ecpp_pkg::CNT_W-1:0] seen, seen_next;
  logic [13:0]                held_pt, held_pt_next;
  logic [2:0]                 held_pid, held_pid_next;

  logic [11:0]                raw_cnt;
  logic [ecpp_pkg::CNT_W-1:0] cnt;
  logic [13:0]                pt;
  logic [2:0]                 pid;
  logic                       open;
  logic                       final_cand;
  logic [1:0]                 port_adv;

  assign req_ready = !q_full;

  assign raw_cnt  = req.word[11:0];
  assign cnt      = (raw_cnt > 12'(ecpp_pkg::MAX_CANDIDATES))
                    ? ecpp_pkg::CNT_W'(ecpp_pkg::MAX_CANDIDATES)
                    : ecpp_pkg::CNT_W'(raw_cnt);
  assign pt       = req.word[13:0];
  assign pid      = req.word[39:37];
  assign open     = (expected != '0) && (seen < expected);
  assign final_cand = (({1'b0, seen} + 1'b1) == {1'b0, expected});
  assign port_adv = (port == ecpp_pkg::PORT_LAST) ? 2'd0 : port + 2'd1;

  always_comb begin
    port_next     = port;
    expected_next = expected;
    seen_next     = seen;
    held_pt_next  = held_pt;
    held_pid_next = held_pid;
    push          = 1'b0;
    cmd           = '0;
    cmd.res.port  = port;
    cmd.wr_idx    = seen;
    cmd.total     = expected;
    cmd.eta       = {{4{req.word[25]}}, req.word[25:14]};
    cmd.phi       = {req.word[36:26], 5'b0};
    if (req_valid && req_ready) begin
      if (req.op == ecpp_pkg::OP_HEADER) begin
        push                   = 1'b1;
        cmd.has_out            = 1'b1;
        cmd.res.first_word     = {16'(cnt), 4'b0, req.word[23:12]};
        cmd.res.second_word    = req.word[55:24];
        cmd.res.byte_keep      = ecpp_pkg::KEEP_FULL;
        cmd.res.run_end        = 1'b1;
        expected_next          = cnt;
        seen_next              = '0;
        held_pt_next           = '0;
        held_pid_next          = '0;
        if (cnt == '0) begin
          expected_next = '0;
          port_next     = port_adv;
        end
      end else if (open) begin
        push        = 1'b1;
        cmd.wr_en   = 1'b1;
        cmd.drain   = final_cand;
        seen_next   = seen + 1'b1;
        cmd.res.stream_last = final_cand;
        cmd.res.run_end     = !final_cand;
        if (seen[0]) begin
          cmd.has_out            = 1'b1;
          cmd.res.first_word     = {2'b0, pt, 2'b0, held_pt};
          cmd.res.second_word    = {13'b0, pid, 13'b0, held_pid};
          cmd.res.byte_keep      = ecpp_pkg::KEEP_FULL;
        end else if (final_cand) begin
          cmd.has_out            = 1'b1;
          cmd.res.first_word     = {18'b0, pt};
          cmd.res.second_word    = {29'b0, pid};
          cmd.res.byte_keep      = ecpp_pkg::KEEP_HALF;
        end else begin
          held_pt_next  = pt;
          held_pid_next = pid;
        end
        if (final_cand) begin
          expected_next = '0;
          seen_next     = '0;
          held_pt_next  = '0;
          held_pid_next = '0;
          port_next     = port_adv;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      port     <= '0;
      expected <= '0;
      seen     <= '0;
      held_pt  <= '0;
      held_pid <= '0;
    end else begin
      port     <= port_next;
      expected <= expected_next;
      seen     <= seen_next;
      held_pt  <= held_pt_next;
      held_pid <= held_pid_next;
    end
  end

endmodule

[rtl/ecpp_queue.sv]
// ----------------------------------------------------------------------------
// ecpp_queue
// Small command FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module ecpp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ecpp_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output ecpp_pkg::cmd_t q_cmd
);

  ecpp_pkg::cmd_t                entries [ecpp_pkg::QUEUE_DEPTH];
  logic [ecpp_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [ecpp_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [ecpp_pkg::QUEUE_AW:0]   fill;

  assign full    = (fill == (ecpp_pkg::QUEUE_AW + 1)'(ecpp_pkg::QUEUE_DEPTH));
  assign q_valid = (fill != '0);
  assign q_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

[rtl/ecpp_back.sv]
// ----------------------------------------------------------------------------
// ecpp_back
// Executes commands: stores eta/phi in two banks (even and odd candidates),
// emits results and drains the eta/phi pairs at the end of an event.
// ----------------------------------------------------------------------------
module ecpp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  ecpp_pkg::cmd_t q_cmd,
  output logic           pop,
  output logic           res_valid,
  input  logic           res_ready,
  output ecpp_pkg::res_t res
);

  ecpp_pkg::back_state_t      state, state_next;
  logic [ecpp_pkg::CNT_W-1:0] j, j_next;
  logic [ecpp_pkg::CNT_W-1:0] total;
  logic [1:0]                 drain_port;

  // {eta, phi} per entry
  logic [31:0] even_mem [ecpp_pkg::BANK_DEPTH];
  logic [31:0] odd_mem  [ecpp_pkg::BANK_DEPTH];
  logic [31:0] even_rd;
  logic [31:0] odd_rd;
  logic [ecpp_pkg::BANK_AW-1:0] wr_addr;
  logic [ecpp_pkg::BANK_AW-1:0] rd_addr;

  logic           can_load;
  logic           load_cmd;
  logic           load_drain;
  logic           pair;
  logic           last;
  ecpp_pkg::res_t drain_res;

  assign can_load = !res_valid || res_ready;
  assign wr_addr  = q_cmd.wr_idx[ecpp_pkg::BANK_AW:1];
  assign rd_addr  = j[ecpp_pkg::BANK_AW:1];
  assign pair     = (({1'b0, j} + 1'b1) < {1'b0, total});
  assign last     = (({1'b0, j} + 2'd2) >= {1'b0, total});

  always_comb begin
    drain_res             = '0;
    drain_res.port        = drain_port;
    drain_res.stream_last = last;
    drain_res.run_end     = last;
    if (pair) begin
      drain_res.first_word  = {odd_rd[31:16], even_rd[31:16]};
      drain_res.second_word = {odd_rd[15:0], even_rd[15:0]};
      drain_res.byte_keep   = ecpp_pkg::KEEP_FULL;
    end else begin
      drain_res.first_word  = {16'b0, even_rd[31:16]};
      drain_res.second_word = {16'b0, even_rd[15:0]};
      drain_res.byte_keep   = ecpp_pkg::KEEP_HALF;
    end
  end

  always_comb begin
    state_next = state;
    j_next     = j;
    pop        = 1'b0;
    load_cmd   = 1'b0;
    load_drain = 1'b0;
    case (state)
      ecpp_pkg::ST_CMD: begin
        if (q_valid && (!q_cmd.has_out || can_load)) begin
          pop      = 1'b1;
          load_cmd = q_cmd.has_out;
          if (q_cmd.drain) begin
            j_next     = '0;
            state_next = ecpp_pkg::ST_READ;
          end
        end
      end
      ecpp_pkg::ST_READ: begin
        state_next = ecpp_pkg::ST_EMIT;
      end
      ecpp_pkg::ST_EMIT: begin
        if (can_load) begin
          load_drain = 1'b1;
          if (last) begin
            state_next = ecpp_pkg::ST_CMD;
          end else begin
            j_next     = j + 2'd2;
            state_next = ecpp_pkg::ST_READ;
          end
        end
      end
      default: begin
        state_next = ecpp_pkg::ST_CMD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ecpp_pkg::ST_CMD;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    j <= j_next;
    if (pop && q_cmd.drain) begin
      total      <= q_cmd.total;
      drain_port <= q_cmd.res.port;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_cmd.wr_en && !q_cmd.wr_idx[0]) begin
      even_mem[wr_addr] <= {q_cmd.eta, q_cmd.phi};
    end
    even_rd <= even_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (pop && q_cmd.wr_en && q_cmd.wr_idx[0]) begin
      odd_mem[wr_addr] <= {q_cmd.eta, q_cmd.phi};
    end
    odd_rd <= odd_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_cmd || load_drain) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_cmd) begin
      res <= q_cmd.res;
    end else if (load_drain) begin
      res <= drain_res;
    end
  end

endmodule

[rtl/event_candidate_unpack_and_pair_pack_unit.sv]
// ----------------------------------------------------------------------------
// event_candidate_unpack_and_pair_pack_unit
// Unpacks event header and candidate words and packs them as 32-bit pairs.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready/req): op 0 is an event header word,
//   op 1 a candidate word. Result channel (res_valid/res_ready/res) carries
//   one 32-bit word for each stream of the selected port pair, with keep,
//   last and run_end (last result caused by a request).
//   A result is loaded into the output register at the edge that pops its
//   command from the queue.
//   Throughput: one request per cycle into a four-entry command queue while
//   it is not full; the back end retires one command per cycle while the
//   output register can take it. The eta/phi drain after the final candidate
//   does a registered bank read, then an emit, for each output word.
//   A receiver stall holds the output register and backs up the queue; once
//   the queue is full req_ready drops.
//   Reset clears the port select, the event tracking, the queue and the
//   output valid flag. The eta/phi banks are not cleared; an entry is always
//   written within an event before it is read.
// ----------------------------------------------------------------------------
module event_candidate_unpack_and_pair_pack_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  ecpp_pkg::req_t req,
  output logic           res_valid,
  input  logic           res_ready,
  output ecpp_pkg::res_t res
);

  logic           push;
  ecpp_pkg::cmd_t push_cmd;
  logic           q_full;
  logic           pop;
  logic           q_valid;
  ecpp_pkg::cmd_t q_cmd;

  // front: event tracking, pt/pid pairing, command generation
  ecpp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .q_full    (q_full),
    .push      (push),
    .cmd       (push_cmd)
  );

  // decouples request intake from result emission
  ecpp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  // back: eta/phi storage, drain sequencing, output register
  ecpp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

[tb/tb_event_candidate_unpack_and_pair_pack_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_event_candidate_unpack_and_pair_pack_unit
// Drives event header and candidate words and checks every packed output word.
// A directed table opens the run: extremes, clamped and zero counts, an event
// dropped by a new header, stray candidates and odd tails. Then come random
// events, mostly well formed, some cut short, some stray words. A local
// unpacker works out the expected words for each accepted request, and each
// output word is compared field by field in arrival order. Both sides idle at
// random between requests, with stretches of full speed.
// ----------------------------------------------------------------------------
module tb_event_candidate_unpack_and_pair_pack_unit;

  localparam int RESET_CYCLES = 11;
  localparam int RAND_ITEMS   = 90;
  // Worst event drains 32 pair words behind a full queue.
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 300000;

  // Directed table row: the expected word is typed in only where it is obvious.
  typedef struct {
    ecpp_pkg::req_t item;
    bit             typed;
    ecpp_pkg::res_t want;
  } plan_row_t;

  // One entry per request in flight on the request channel.
  typedef struct {
    bit             typed;
    ecpp_pkg::res_t want;
  } req_tag_t;

  logic           clk;
  logic           rst = 1'b1;
  logic           req_valid;
  logic           req_ready;
  ecpp_pkg::req_t req;
  logic           res_valid;
  logic           res_ready;
  ecpp_pkg::res_t res;

  event_candidate_unpack_and_pair_pack_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Unpacker state: port pair, open event tracking, held pt/pid half and the
  // eta/phi values seen so far in the open event.
  // --------------------------------------------------------------------------
  logic [1:0]  cur_port;
  int unsigned open_count;
  int unsigned seen_cands;
  logic [13:0] held_pt;
  logic [2:0]  held_pid;
  logic [15:0] eta_mem [ecpp_pkg::MAX_CANDIDATES];
  logic [15:0] phi_mem [ecpp_pkg::MAX_CANDIDATES];

  ecpp_pkg::res_t step_words [$];    // words produced by the latest request
  ecpp_pkg::res_t pending_words [$]; // expected words not yet seen on the output
  req_tag_t       req_tags [$];
  plan_row_t      dir_plan [$];

  int unsigned mismatches = 0;
  int unsigned live_items = 0;   // requests that were not simply dropped
  int unsigned cycles = 0;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;

  function automatic void emit_word(logic [31:0] a, logic [31:0] b, logic [3:0] keep,
                                    logic last);
    ecpp_pkg::res_t w;
    w.port        = cur_port;
    w.first_word  = a;
    w.second_word = b;
    w.byte_keep   = keep;
    w.stream_last = last;
    w.run_end     = 1'b0; // set when the words move to the pending list
    step_words.push_back(w);
  endfunction

  function automatic void close_event();
    open_count = 0;
    seen_cands = 0;
    held_pt    = '0;
    held_pid   = '0;
    cur_port   = (cur_port == ecpp_pkg::PORT_LAST) ? 2'd0 : cur_port + 2'd1;
  endfunction

  // Expected words for one accepted request; flags a candidate with no event.
  task automatic unpack_predict(input ecpp_pkg::req_t r, output bit dropped);
    int unsigned cnt;
    int unsigned idx;
    int unsigned j;
    logic [13:0] pt;
    logic [2:0]  pid;
    logic [31:0] a;
    logic [31:0] b;
    bit          pair;
    bit          final_cand;
    step_words.delete();
    dropped = 1'b0;
    if (r.op == ecpp_pkg::OP_HEADER) begin
      // A header always restarts tracking; an unfinished event is lost.
      cnt = r.word[11:0];
      if (cnt > ecpp_pkg::MAX_CANDIDATES) cnt = ecpp_pkg::MAX_CANDIDATES;
      open_count = cnt;
      seen_cands = 0;
      held_pt    = '0;
      held_pid   = '0;
      emit_word(32'(r.word[23:12]) | (32'(cnt) << 16), r.word[55:24],
                ecpp_pkg::KEEP_FULL, 1'b0);
      if (cnt == 0) close_event();
    end else if (open_count == 0 || seen_cands >= open_count) begin
      dropped = 1'b1;
    end else begin
      idx = seen_cands;
      pt  = r.word[13:0];
      pid = r.word[39:37];
      eta_mem[idx] = {{4{r.word[25]}}, r.word[25:14]};
      phi_mem[idx] = {r.word[36:26], 5'b0};
      seen_cands = idx + 1;
      final_cand = (seen_cands == open_count);
      if (idx % 2 == 1) begin
        emit_word((32'(pt) << 16) | 32'(held_pt), (32'(pid) << 16) | 32'(held_pid),
                  ecpp_pkg::KEEP_FULL, final_cand);
      end else if (final_cand) begin
        emit_word(32'(pt), 32'(pid), ecpp_pkg::KEEP_HALF, 1'b1);
      end else begin
        held_pt  = pt;
        held_pid = pid;
      end
      if (final_cand) begin
        // eta/phi of the whole event, two per word, odd tail in the low half
        for (j = 0; j < open_count; j += 2) begin
          pair = (j + 1 < open_count);
          a = 32'(eta_mem[j]);
          b = 32'(phi_mem[j]);
          if (pair) begin
            a |= 32'(eta_mem[j+1]) << 16;
            b |= 32'(phi_mem[j+1]) << 16;
          end
          emit_word(a, b, pair ? ecpp_pkg::KEEP_FULL : ecpp_pkg::KEEP_HALF,
                    j + 2 >= open_count);
        end
        close_event();
      end
    end
  endtask

  task automatic compare_fields(input ecpp_pkg::res_t want, input ecpp_pkg::res_t got);
    if (got.port !== want.port) begin
      $error("port: expected %0d, got %0d", want.port, got.port);
      mismatches++;
    end
    if (got.first_word !== want.first_word) begin
      $error("first_word: expected %08h, got %08h", want.first_word, got.first_word);
      mismatches++;
    end
    if (got.second_word !== want.second_word) begin
      $error("second_word: expected %08h, got %08h", want.second_word, got.second_word);
      mismatches++;
    end
    if (got.byte_keep !== want.byte_keep) begin
      $error("byte_keep: expected %h, got %h", want.byte_keep, got.byte_keep);
      mismatches++;
    end
    if (got.stream_last !== want.stream_last) begin
      $error("stream_last: expected %0b, got %0b", want.stream_last, got.stream_last);
      mismatches++;
    end
    if (got.run_end !== want.run_end) begin
      $error("run_end: expected %0b, got %0b", want.run_end, got.run_end);
      mismatches++;
    end
  endtask

  // Header word result as it can be read straight off the field layout.
  function automatic ecpp_pkg::res_t header_word(logic [1:0] port, logic [15:0] cnt,
                                                 logic [11:0] bx, logic [31:0] orbit);
    ecpp_pkg::res_t w;
    w.port        = port;
    w.first_word  = {cnt, 4'h0, bx};
    w.second_word = orbit;
    w.byte_keep   = ecpp_pkg::KEEP_FULL;
    w.stream_last = 1'b0;
    w.run_end     = 1'b1;
    return w;
  endfunction

  function automatic plan_row_t plan_row(logic op, logic [63:0] w, bit typed,
                                         ecpp_pkg::res_t want);
    plan_row_t p;
    p.item.op   = op;
    p.item.word = w;
    p.typed     = typed;
    p.want      = want;
    return p;
  endfunction

  // Present one request after a random gap and hold it until taken.
  task automatic send(input logic op, input logic [63:0] w, input bit typed,
                      input ecpp_pkg::res_t want);
    int unsigned gap;
    req_tag_t    tag;
    if ($urandom_range(0, 15) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tag.typed = typed;
    tag.want  = want;
    req_tags.push_back(tag);
    req_valid <= 1'b1;
    req.op    <= op;
    req.word  <= w;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Monitor: predict on every accepted request, check every accepted word.
  // Prediction runs before the check so a same-edge result still finds it.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    req_tag_t       tag;
    bit             dropped;
    ecpp_pkg::res_t w;
    if (!rst) begin
      if (req_valid && req_ready) begin
        tag = req_tags.pop_front();
        unpack_predict(req, dropped);
        if (!dropped) live_items <= live_items + 1;
        if (tag.typed) begin
          pending_words.push_back(tag.want);
        end else begin
          foreach (step_words[i]) begin
            w = step_words[i];
            w.run_end = (i == step_words.size() - 1);
            pending_words.push_back(w);
          end
        end
      end
      if (res_valid && res_ready) begin
        if (pending_words.size() == 0) begin
          $error("unexpected word: port %0d first %08h second %08h keep %h",
                 res.port, res.first_word, res.second_word, res.byte_keep);
          mismatches++;
        end else begin
          compare_fields(pending_words.pop_front(), res);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[event_candidate_unpack_and_pair_pack_unit] ERROR");
      $finish;
    end
  end

  // Receiver: random stall before each word, with stretches of none.
  initial begin
    int unsigned gap;
    res_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_steady = !rx_steady;
      gap = rx_steady ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
        res_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ready <= 1'b1;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned kind;
    int unsigned n;
    int unsigned feed;
    int unsigned k;
    logic [11:0] cnt12;
    logic [63:0] w;
    req_valid <= 1'b0;
    req       <= '0;
    cur_port   = '0;
    open_count = 0;
    seen_cands = 0;
    held_pt    = '0;
    held_pid   = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero count with every other header bit set: header only, port moves on
    dir_plan.push_back(plan_row(ecpp_pkg::OP_HEADER, 64'hFFFF_FFFF_FFFF_F000, 1'b1,
                                header_word(2'd0, 16'd0, 12'hFFF, 32'hFFFF_FFFF)));
    // candidate with no open event is dropped
    dir_plan.push_back(plan_row(ecpp_pkg::OP_CAND, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0));
    // count at its field maximum clamps
    dir_plan.push_back(plan_row(ecpp_pkg::OP_HEADER, 64'h0000_0000_0000_0FFF, 1'b1,
                                header_word(2'd1, 16'(ecpp_pkg::MAX_CANDIDATES), 12'h000,
                                            32'h0)));
    dir_plan.push_back(plan_row(ecpp_pkg::OP_CAND, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0));
    dir_plan.push_back(plan_row(ecpp_pkg::OP_CAND, 64'h0000_0000_0000_0000, 1'b0, '0));
    // new header mid-event drops it and keeps the same port
    dir_plan.push_back(plan_row(ecpp_pkg::OP_HEADER,
                                {8'h00, 32'h89AB_CDEF, 12'h123, 12'd3}, 1'b1,
                                header_word(2'd1, 16'd3, 12'h123, 32'h89AB_CDEF)));
    // eta sign bit set, then max positive eta, then odd tail
    dir_plan.push_back(plan_row(ecpp_pkg::OP_CAND, 64'h0000_00E0_0200_3FFF, 1'b0, '0));
    dir_plan.push_back(plan_row(ecpp_pkg::OP_CAND, 64'h0000_0015_FDFF_C001, 1'b0, '0));
    dir_plan.push_back(plan_row(ecpp_pkg::OP_CAND, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0, '0));
    // even count on the last port pair, then wrap
    dir_plan.push_back(plan_row(ecpp_pkg::OP_HEADER,
                                {8'hA5, 32'h0000_0001, 12'h7FF, 12'd2}, 1'b1,
                                header_word(ecpp_pkg::PORT_LAST, 16'd2, 12'h7FF,
                                            32'h0000_0001)));
    dir_plan.push_back(plan_row(ecpp_pkg::OP_CAND, 64'h0123_4567_89AB_CDEF, 1'b0, '0));
    dir_plan.push_back(plan_row(ecpp_pkg::OP_CAND, 64'hFEDC_BA98_7654_3210, 1'b0, '0));
    // extra candidate after the event closed
    dir_plan.push_back(plan_row(ecpp_pkg::OP_CAND, 64'h8000_0000_0000_0001, 1'b0, '0));
    // single candidate: one half word for pt/pid and for eta/phi
    dir_plan.push_back(plan_row(ecpp_pkg::OP_HEADER,
                                {8'h00, 32'h8000_0000, 12'h800, 12'd1}, 1'b1,
                                header_word(2'd0, 16'd1, 12'h800, 32'h8000_0000)));
    dir_plan.push_back(plan_row(ecpp_pkg::OP_CAND, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0));
    // just over the limit clamps, then a zero header drops that event
    dir_plan.push_back(plan_row(ecpp_pkg::OP_HEADER,
                                {8'h00, 32'h1234_5678, 12'hABC, 12'd65}, 1'b1,
                                header_word(2'd1, 16'(ecpp_pkg::MAX_CANDIDATES), 12'hABC,
                                            32'h1234_5678)));
    dir_plan.push_back(plan_row(ecpp_pkg::OP_HEADER,
                                {8'h3C, 32'h5555_AAAA, 12'h555, 12'd0}, 1'b1,
                                header_word(2'd1, 16'd0, 12'h555, 32'h5555_AAAA)));

    foreach (dir_plan[i])
      send(dir_plan[i].item.op, dir_plan[i].item.word, dir_plan[i].typed, dir_plan[i].want);

    // Random events: mostly complete, a few long or clamped, some cut short,
    // some stray candidates and empty events.
    while (live_items < dir_plan.size() + RAND_ITEMS) begin
      kind = $urandom_range(0, 9);
      k    = $urandom_range(0, 15);
      if (k == 0) begin
        n     = $urandom_range(9, ecpp_pkg::MAX_CANDIDATES);
        cnt12 = 12'(n);
      end else if (k == 1) begin
        cnt12 = 12'($urandom_range(ecpp_pkg::MAX_CANDIDATES + 1, 4095));
        n     = ecpp_pkg::MAX_CANDIDATES + $urandom_range(0, 2);
      end else begin
        n     = $urandom_range(1, 8);
        cnt12 = 12'(n);
      end
      w = {$urandom, $urandom};
      if (kind <= 6) begin
        w[11:0] = cnt12;
        send(ecpp_pkg::OP_HEADER, w, 1'b0, '0);
        repeat (n) send(ecpp_pkg::OP_CAND, {$urandom, $urandom}, 1'b0, '0);
      end else if (kind == 7) begin
        n       = $urandom_range(2, 8);
        w[11:0] = 12'(n);
        feed    = $urandom_range(0, n - 1);
        send(ecpp_pkg::OP_HEADER, w, 1'b0, '0);
        repeat (feed) send(ecpp_pkg::OP_CAND, {$urandom, $urandom}, 1'b0, '0);
      end else if (kind == 8) begin
        repeat ($urandom_range(1, 2))
          send(ecpp_pkg::OP_CAND, {$urandom, $urandom}, 1'b0, '0);
      end else begin
        w[11:0] = 12'd0;
        send(ecpp_pkg::OP_HEADER, w, 1'b0, '0);
      end
    end
    req_valid <= 1'b0;

    // Wait out every expected word, then give stray words a chance to show.
    while (pending_words.size() != 0 || req_tags.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[event_candidate_unpack_and_pair_pack_unit] OK");
    end else begin
      $display("[event_candidate_unpack_and_pair_pack_unit] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/ecpp_pkg.sv
rtl/ecpp_front.sv
rtl/ecpp_queue.sv
rtl/ecpp_back.sv
rtl/event_candidate_unpack_and_pair_pack_unit.sv
tb/tb_event_candidate_unpack_and_pair_pack_unit.sv
